FILE: design/sha256_digest_macros.svh
// Assertion macros for the SHA-256 digest block
`ifndef SHA256_DIGEST_MACROS_SVH
`define SHA256_DIGEST_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk_sig, rst_sig, pre, post) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |-> (post)) \
        else $error("sha256 assertion failed");
`define SHA_ASSERT_NEXT(label, clk_sig, rst_sig, pre, post) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |=> (post)) \
        else $error("sha256 assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk_sig, rst_sig, pre, post)
`define SHA_ASSERT_NEXT(label, clk_sig, rst_sig, pre, post)
`endif
`endif

FILE: design/sha_pkg.sv
package sha_pkg;

    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_cmd_t;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PadByte = 8'h80;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        ror32 = (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: design/sha_if.sv
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: design/sha256_digest.sv
// A byte transaction is registered in the command queue, then taken by the engine when it is idle.
// The 64th byte of a block adds 64 rounds and a fold before the next byte is taken.
// End of message: pad, 64 rounds and fold (a second pass when the length spills, and the
// full-block pass first when the message ends on a block boundary), then 8 words.
// Bytes wait while the single round unit compresses a block, so that unit sets the byte rate.
// Reset (rst_n low, asynchronous) loads the initial hash values and clears counts.
`include "sha256_digest_macros.svh"
module sha256_digest
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    sha_cmd_t cmd;
    logic     cmd_valid;
    logic     cmd_take;

    sha_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    sha_engine u_engine (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .out_ch(out_ch)
    );

    `SHA_ASSERT_IMPL(a_no_take_while_out, clk, rst_n, out_ch.valid, !cmd_take)
    `SHA_ASSERT_NEXT(a_idx_steps, clk, rst_n, out_ch.valid && out_ch.ready && !out_ch.last_word, out_ch.valid && out_ch.word_index == $past(out_ch.word_index) + 3'd1)
    `SHA_ASSERT_NEXT(a_last_ends, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.last_word, !out_ch.valid)
endmodule

FILE: design/sha_queue.sv
module sha_queue
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sha_in_if.sink   in_ch,
    output sha_cmd_t cmd,
    output logic     cmd_valid,
    input  logic     cmd_take
);
    // two-entry command queue between intake and the hashing engine
    sha_cmd_t   mem_reg [QueueDepth];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ch.ready = (count_reg != 2'(QueueDepth));
    // items with neither byte nor end are dropped at intake
    assign push = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.end_of_message);
    assign cmd_valid = (count_reg != 2'd0);
    assign pop = cmd_valid && cmd_take;
    assign cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: design/sha_engine.sv
module sha_engine
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sha_cmd_t  cmd,
    input  logic      cmd_valid,
    output logic      cmd_take,
    sha_out_if.source out_ch
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_ROUND, S_FOLD, S_EMIT
    } state_t;

    state_t      state_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [63:0] count_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic        ending_reg;
    logic        lenblk_reg;
    logic [2:0]  idx_reg;
    logic        ovalid_reg;
    logic [31:0] oword_reg;

    logic [31:0] t1, t2, s0, s1, w_new, e, a;
    logic [63:0] bits;

    assign cmd_take = (state_reg == S_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.digest_word = oword_reg;
    assign out_ch.word_index = idx_reg;
    assign out_ch.last_word = (idx_reg == 3'd7);
    assign bits = {count_reg[60:0], 3'b000};

    // one round: schedule word from the sliding window and round update
    always_comb
    begin
        e = v_reg[4];
        a = v_reg[0];
        s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = v_reg[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + RoundK[round_reg] + w_reg[0];
        t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            h_reg      <= InitH;
            count_reg  <= '0;
            fill_reg   <= '0;
            round_reg  <= '0;
            ending_reg <= 1'b0;
            lenblk_reg <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        ending_reg <= cmd.end_of_message;
                        if (cmd.has_byte)
                        begin
                            w_reg[fill_reg[5:2]][(3 - fill_reg[1:0]) * 8 +: 8] <= cmd.data_byte;
                            count_reg <= count_reg + 64'd1;
                            fill_reg  <= fill_reg + 6'd1;
                        end
                        if (cmd.has_byte && fill_reg == 6'd63)
                        begin
                            v_reg     <= h_reg;
                            round_reg <= '0;
                            lenblk_reg <= 1'b0;
                            state_reg <= S_ROUND;
                        end
                        else if (cmd.end_of_message)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // pad tail of current block and start its compression
                    for (int p = 0; p < 64; p++)
                    begin
                        if (6'(p) == fill_reg)
                        begin
                            w_reg[p / 4][(3 - p % 4) * 8 +: 8] <= PadByte;
                        end
                        else if (6'(p) > fill_reg)
                        begin
                            w_reg[p / 4][(3 - p % 4) * 8 +: 8] <= 8'h00;
                        end
                    end
                    if (fill_reg <= 6'd55)
                    begin
                        w_reg[14] <= bits[63:32];
                        w_reg[15] <= bits[31:0];
                        lenblk_reg <= 1'b1;
                    end
                    else
                    begin
                        lenblk_reg <= 1'b0;
                    end
                    v_reg     <= h_reg;
                    round_reg <= '0;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= w_new;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (!ending_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (lenblk_reg)
                    begin
                        idx_reg    <= '0;
                        oword_reg  <= h_reg[0] + v_reg[0];
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_EMIT;
                    end
                    else if (fill_reg <= 6'd55)
                    begin
                        // message ended on a full block: pad a fresh block
                        state_reg <= S_PAD;
                    end
                    else
                    begin
                        // extra block holding only the length
                        for (int i = 0; i < 14; i++)
                        begin
                            w_reg[i] <= '0;
                        end
                        w_reg[14]  <= bits[63:32];
                        w_reg[15]  <= bits[31:0];
                        v_reg      <= '{h_reg[0] + v_reg[0], h_reg[1] + v_reg[1],
                                        h_reg[2] + v_reg[2], h_reg[3] + v_reg[3],
                                        h_reg[4] + v_reg[4], h_reg[5] + v_reg[5],
                                        h_reg[6] + v_reg[6], h_reg[7] + v_reg[7]};
                        lenblk_reg <= 1'b1;
                        round_reg  <= '0;
                        state_reg  <= S_ROUND;
                    end
                end
                S_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        if (idx_reg == 3'd7)
                        begin
                            ovalid_reg <= 1'b0;
                            h_reg      <= InitH;
                            count_reg  <= '0;
                            fill_reg   <= '0;
                            ending_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            oword_reg <= h_reg[idx_reg + 3'd1];
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
